### rtl/mi3_pkg.sv
// Shared widths, lane types and index helpers for the 3x3 matrix inverse.
package mi3_pkg;

    localparam int ElemW  = 32;            // Q16.16 element
    localparam int ProdW  = 64;            // element product
    localparam int CofW   = 65;            // signed cofactor
    localparam int MagW   = 64;            // cofactor magnitude
    localparam int DetW   = 97;            // signed determinant
    localparam int NumW   = 96;            // dividend and divisor magnitude
    localparam int QuoW   = 33;            // quotient bits kept below the overflow check
    localparam int DivSteps = QuoW;        // one quotient bit per stage
    localparam int WideW  = NumW + QuoW;   // width of the shifted compare

    typedef logic signed [ElemW-1:0] elem_t;
    typedef logic [3:0]              idx_t;

    typedef struct packed {
        logic [NumW-1:0] rem;
        logic [QuoW-1:0] quo;
        logic            ovf;
        logic            neg;
    } div_lane_t;

    typedef struct packed {
        logic                  valid;
        logic                  zero;
        logic [NumW-1:0]       dmag;
        div_lane_t [8:0]       lane;
    } div_stage_t;

    // Flat position of element (r, c), both wrapped into 0..2.
    function automatic idx_t pos(input int r, input int c);
        int rr;
        int cc;
        rr = (r >= 3) ? r - 3 : r;
        cc = (c >= 3) ? c - 3 : c;
        return idx_t'(rr * 3 + cc);
    endfunction

endpackage

### rtl/matrix3x3_inverse.sv
// Throughput: one matrix per cycle unless stalled; the 33-stage restoring divider bank (nine
// lanes, one quotient bit per stage) and the partial-product determinant stages set the depth.
// Backpressure stalls every stage together; one input skid register keeps s_ready registered.
// Reset (aresetn, synchronous, active low) clears the valid bits and the skid; data is not reset.
// No state is kept between matrices.
module matrix3x3_inverse (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mi3_pkg::elem_t       s_m00,
    input  mi3_pkg::elem_t       s_m01,
    input  mi3_pkg::elem_t       s_m02,
    input  mi3_pkg::elem_t       s_m10,
    input  mi3_pkg::elem_t       s_m11,
    input  mi3_pkg::elem_t       s_m12,
    input  mi3_pkg::elem_t       s_m20,
    input  mi3_pkg::elem_t       s_m21,
    input  mi3_pkg::elem_t       s_m22,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mi3_pkg::elem_t       m_inv00,
    output mi3_pkg::elem_t       m_inv01,
    output mi3_pkg::elem_t       m_inv02,
    output mi3_pkg::elem_t       m_inv10,
    output mi3_pkg::elem_t       m_inv11,
    output mi3_pkg::elem_t       m_inv12,
    output mi3_pkg::elem_t       m_inv20,
    output mi3_pkg::elem_t       m_inv21,
    output mi3_pkg::elem_t       m_inv22,
    output logic                 m_singular
);
    import mi3_pkg::*;

    logic  pipe_en;
    elem_t in_m [9];
    elem_t head_m [9];
    logic  head_valid;

    logic  skid_full_reg, skid_full_next;
    elem_t skid_reg [9];

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [ProdW-1:0] p_reg [9];
    logic signed [ProdW-1:0] q_reg [9];
    elem_t                   m0a_reg [3];
    elem_t                   m0b_reg [3];
    logic signed [CofW-1:0]  cof_reg [9];
    logic signed [CofW-1:0]  dlo_reg [3];
    logic signed [CofW-1:0]  dhi_reg [3];
    logic [MagW-1:0]         cmag3_reg [9], cmag4_reg [9], cmag5_reg [9], cmag6_reg [9];
    logic                    cneg3_reg [9], cneg4_reg [9], cneg5_reg [9], cneg6_reg [9];
    logic signed [DetW-1:0]  term_reg [3];
    logic signed [DetW-1:0]  det_reg;
    logic [NumW-1:0]         dmag_reg;
    logic                    dneg_reg;
    logic                    dzero_reg;

    div_stage_t div_reg  [DivSteps+1];
    div_stage_t div_next [DivSteps+1];

    logic  m_valid_reg;
    logic  singular_reg;
    elem_t out_reg [9];

    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = !skid_full_reg;

    assign in_m[0] = s_m00;
    assign in_m[1] = s_m01;
    assign in_m[2] = s_m02;
    assign in_m[3] = s_m10;
    assign in_m[4] = s_m11;
    assign in_m[5] = s_m12;
    assign in_m[6] = s_m20;
    assign in_m[7] = s_m21;
    assign in_m[8] = s_m22;

    assign head_valid = skid_full_reg || s_valid;
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            head_m[k] = skid_full_reg ? skid_reg[k] : in_m[k];
        end
    end

    // Hold a request in the skid when it arrives during a stall.
    always_comb begin
        if (skid_full_reg) begin
            skid_full_next = !pipe_en;
        end else begin
            skid_full_next = s_valid && !pipe_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else begin
            skid_full_reg <= skid_full_next;
        end
        if (!skid_full_reg && s_valid && !pipe_en) begin
            skid_reg <= in_m;
        end
    end

    // Front stages: products, cofactors, determinant partial products and sum.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= head_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    p_reg[pos(i, j)] <= ProdW'(head_m[pos(i + 1, j + 1)])
                                      * ProdW'(head_m[pos(i + 2, j + 2)]);
                    q_reg[pos(i, j)] <= ProdW'(head_m[pos(i + 1, j + 2)])
                                      * ProdW'(head_m[pos(i + 2, j + 1)]);
                end
                m0a_reg[i] <= head_m[pos(0, i)];
            end
            m0b_reg <= m0a_reg;
            for (int k = 0; k < 9; k++) begin
                cof_reg[k]   <= CofW'(p_reg[k]) - CofW'(q_reg[k]);
                cmag3_reg[k] <= cof_reg[k][CofW-1] ? MagW'(-cof_reg[k]) : MagW'(cof_reg[k]);
                cneg3_reg[k] <= cof_reg[k][CofW-1];
            end
            // Split each row-0 cofactor into an unsigned low word and a signed high part.
            for (int j = 0; j < 3; j++) begin
                dlo_reg[j] <= CofW'(signed'({1'b0, cof_reg[j][31:0]})) * CofW'(m0b_reg[j]);
                dhi_reg[j] <= CofW'($signed(cof_reg[j][CofW-1:32])) * CofW'(m0b_reg[j]);
                term_reg[j] <= (DetW'(dhi_reg[j]) <<< 32) + DetW'(dlo_reg[j]);
            end
            cmag4_reg <= cmag3_reg;
            cneg4_reg <= cneg3_reg;
            det_reg   <= term_reg[0] + term_reg[1] + term_reg[2];
            cmag5_reg <= cmag4_reg;
            cneg5_reg <= cneg4_reg;
            dmag_reg  <= det_reg[DetW-1] ? NumW'(-det_reg) : NumW'(det_reg);
            dneg_reg  <= det_reg[DetW-1];
            dzero_reg <= (det_reg == '0);
            cmag6_reg <= cmag5_reg;
            cneg6_reg <= cneg5_reg;
        end
    end

    always_comb begin
        logic [WideW-1:0] rem_w;
        logic [WideW-1:0] div_w;
        // Divider entry: transpose the cofactors and flag quotients of 2^33 or more.
        div_next[0].valid = v6_reg;
        div_next[0].zero  = dzero_reg;
        div_next[0].dmag  = dmag_reg;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                div_next[0].lane[pos(r, c)].rem = {cmag6_reg[pos(c, r)], 32'b0};
                div_next[0].lane[pos(r, c)].quo = '0;
                div_next[0].lane[pos(r, c)].neg = cneg6_reg[pos(c, r)] ^ dneg_reg;
                div_next[0].lane[pos(r, c)].ovf =
                    {{QuoW{1'b0}}, cmag6_reg[pos(c, r)], 32'b0} >= {dmag_reg, {QuoW{1'b0}}};
            end
        end
        // One restoring step per stage, most significant quotient bit first.
        for (int s = 1; s <= DivSteps; s++) begin
            div_next[s] = div_reg[s-1];
            for (int k = 0; k < 9; k++) begin
                rem_w = {{QuoW{1'b0}}, div_reg[s-1].lane[k].rem};
                div_w = {{QuoW{1'b0}}, div_reg[s-1].dmag} << (DivSteps - s);
                if (rem_w >= div_w) begin
                    div_next[s].lane[k].rem = NumW'(rem_w - div_w);
                    div_next[s].lane[k].quo[DivSteps - s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s <= DivSteps; s++) begin
            if (!aresetn) begin
                div_reg[s].valid <= 1'b0;
            end else if (pipe_en) begin
                div_reg[s] <= div_next[s];
            end
        end
    end

    // Saturate to Q16.16 and register the result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= div_reg[DivSteps].valid;
        end
        if (pipe_en) begin
            singular_reg <= div_reg[DivSteps].zero;
            for (int k = 0; k < 9; k++) begin
                if (div_reg[DivSteps].zero) begin
                    out_reg[k] <= '0;
                end else if (div_reg[DivSteps].lane[k].neg) begin
                    if (div_reg[DivSteps].lane[k].ovf
                        || div_reg[DivSteps].lane[k].quo > QuoW'(33'h0_8000_0000)) begin
                        out_reg[k] <= elem_t'(32'h8000_0000);
                    end else begin
                        out_reg[k] <= elem_t'(-div_reg[DivSteps].lane[k].quo[ElemW-1:0]);
                    end
                end else begin
                    if (div_reg[DivSteps].lane[k].ovf
                        || div_reg[DivSteps].lane[k].quo[QuoW-1]
                        || div_reg[DivSteps].lane[k].quo[ElemW-1]) begin
                        out_reg[k] <= elem_t'(32'h7FFF_FFFF);
                    end else begin
                        out_reg[k] <= elem_t'(div_reg[DivSteps].lane[k].quo[ElemW-1:0]);
                    end
                end
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_singular = singular_reg;
    assign m_inv00    = out_reg[0];
    assign m_inv01    = out_reg[1];
    assign m_inv02    = out_reg[2];
    assign m_inv10    = out_reg[3];
    assign m_inv11    = out_reg[4];
    assign m_inv12    = out_reg[5];
    assign m_inv20    = out_reg[6];
    assign m_inv21    = out_reg[7];
    assign m_inv22    = out_reg[8];

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> m_inv00 == '0 && m_inv11 == '0 && m_inv22 == '0
                                  && m_inv01 == '0 && m_inv12 == '0 && m_inv20 == '0)
        else $error("singular result carries nonzero elements");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !skid_full_reg && skid_full_next |-> !pipe_en)
        else $error("skid loaded while pipeline advancing");

    a_stall_holds_divider: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(div_reg[DivSteps].lane) && $stable(div_reg[DivSteps].valid))
        else $error("divider output moved during stall");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg && pipe_en |=> !skid_full_reg)
        else $error("skid not drained on advance");

endmodule

### tb/sv/tb_matrix3x3_inverse.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse with random handshake stalls.
`timescale 1ns / 100ps

module tb_matrix3x3_inverse;
    import mi3_pkg::*;

    localparam int NumRandom = 880;
    localparam int HoldOff   = 300;
    localparam int Drain     = 60;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        elem_t m [9];
    } matrix_t;

    typedef struct {
        elem_t inv [9];
        logic  singular;
    } inverse_t;

    class inverse_scoreboard;
        inverse_t expected_q[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // Transposed cofactors over the exact determinant, truncated and saturated.
        function inverse_t compute_inverse(matrix_t a);
            inverse_t    res;
            wide_t       cof [9];
            wide_t       det;
            wide_t       c;
            logic [255:0] dmag;
            logic [255:0] num;
            logic [255:0] quo;
            logic        neg;
            int          r1, r2, c1, c2;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r1 = (r + 1) % 3;
                    r2 = (r + 2) % 3;
                    c1 = (k + 1) % 3;
                    c2 = (k + 2) % 3;
                    cof[r*3+k] = wide_t'(a.m[r1*3+c1]) * wide_t'(a.m[r2*3+c2])
                               - wide_t'(a.m[r1*3+c2]) * wide_t'(a.m[r2*3+c1]);
                end
            end
            det = wide_t'(a.m[0]) * cof[0] + wide_t'(a.m[1]) * cof[1]
                + wide_t'(a.m[2]) * cof[2];
            res.singular = (det == 0);
            if (det == 0) begin
                foreach (res.inv[k]) res.inv[k] = '0;
                return res;
            end
            dmag = (det < 0) ? -det : det;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    c   = cof[k*3+r];
                    num = (c < 0) ? -c : c;
                    num = num << 32;
                    quo = num / dmag;
                    neg = (c < 0) != (det < 0);
                    if (neg)
                        res.inv[r*3+k] = (quo > 256'h8000_0000) ? elem_t'(32'h8000_0000)
                                                                : elem_t'(-quo);
                    else
                        res.inv[r*3+k] = (quo > 256'h7FFF_FFFF) ? elem_t'(32'h7FFF_FFFF)
                                                                : elem_t'(quo);
                end
            end
            return res;
        endfunction

        function void note_request(matrix_t a);
            expected_q.push_back(compute_inverse(a));
        endfunction

        function void check_result(inverse_t act);
            inverse_t exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            foreach (act.inv[k]) begin
                if (act.inv[k] !== exp_r.inv[k]) begin
                    $display("%0t: inv%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                             exp_r.inv[k], act.inv[k]);
                    errors++;
                end
            end
            if (act.singular !== exp_r.singular) begin
                $display("%0t: singular expected %b actual %b", $time, exp_r.singular,
                         act.singular);
                errors++;
            end
        endfunction
    endclass

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    elem_t s_m [9] = '{default: '0};
    logic  m_valid;
    logic  m_ready = 1'b0;
    elem_t m_inv [9];
    logic  m_singular;

    inverse_scoreboard inv_sb = new();
    int    results_seen = 0;
    bit    held_off = 1'b0;

    always #5 aclk = ~aclk;

    matrix3x3_inverse dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_m00     (s_m[0]),
        .s_m01     (s_m[1]),
        .s_m02     (s_m[2]),
        .s_m10     (s_m[3]),
        .s_m11     (s_m[4]),
        .s_m12     (s_m[5]),
        .s_m20     (s_m[6]),
        .s_m21     (s_m[7]),
        .s_m22     (s_m[8]),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_inv00   (m_inv[0]),
        .m_inv01   (m_inv[1]),
        .m_inv02   (m_inv[2]),
        .m_inv10   (m_inv[3]),
        .m_inv11   (m_inv[4]),
        .m_inv12   (m_inv[5]),
        .m_inv20   (m_inv[6]),
        .m_inv21   (m_inv[7]),
        .m_inv22   (m_inv[8]),
        .m_singular(m_singular)
    );

    // Record each accepted request and check each accepted result.
    always @(posedge aclk) begin
        matrix_t  req;
        inverse_t act;
        if (aresetn && s_valid && s_ready) begin
            req.m = s_m;
            inv_sb.note_request(req);
        end
        if (aresetn && m_valid && m_ready) begin
            act.inv = m_inv;
            act.singular = m_singular;
            inv_sb.check_result(act);
            results_seen++;
        end
    end

    task automatic send_matrix(matrix_t a);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_m     <= a.m;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic matrix_t diag(elem_t d);
        matrix_t a;
        foreach (a.m[k]) a.m[k] = (k % 4 == 0) ? d : '0;
        return a;
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t a;
        int      kind;
        kind = $urandom_range(0, 9);
        foreach (a.m[k]) begin
            case (kind)
                0, 1:    a.m[k] = elem_t'($urandom);
                2:       a.m[k] = ($urandom_range(0, 2) == 0) ? elem_t'($urandom) : '0;
                3:       a.m[k] = elem_t'($signed($urandom_range(0, 64)) - 32);
                default: a.m[k] = elem_t'($signed($urandom_range(0, 32'h0008_0000))
                                          - 32'sh0004_0000);
            endcase
        end
        // Make some singular: copy one row onto another.
        if ($urandom_range(0, 9) == 0) begin
            for (int k = 0; k < 3; k++) a.m[6+k] = a.m[$urandom_range(0, 1)*3+k];
        end
        return a;
    endfunction

    task automatic run_stimulus();
        matrix_t a;
        send_matrix(diag(32'sh0001_0000));                 // identity
        send_matrix(diag(32'sh0002_0000));
        send_matrix(diag(32'sh0000_8000));
        send_matrix(diag('0));                             // all zero: singular
        send_matrix(diag(32'sd1));                         // huge inverse: saturates high
        send_matrix(diag(-32'sd1));                        // saturates low
        send_matrix(diag(32'sd2));                         // just above the top of range
        send_matrix(diag(-32'sd2));                        // exactly the bottom of range
        send_matrix(diag(32'sh7FFF_FFFF));
        send_matrix(diag(32'sh8000_0000));
        foreach (a.m[k]) a.m[k] = 32'sh7FFF_FFFF;          // all max: singular
        send_matrix(a);
        foreach (a.m[k]) a.m[k] = 32'sh8000_0000;          // all min: singular
        send_matrix(a);
        foreach (a.m[k]) a.m[k] = (k % 2 == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        send_matrix(a);
        foreach (a.m[k]) a.m[k] = (k == 0 || k == 4 || k == 8) ? 32'sh8000_0000
                                                               : 32'sh7FFF_FFFF;
        send_matrix(a);
        a.m = '{32'sh0002_0000, 32'sh0001_0000, '0, 32'sh0001_0000, 32'sh0003_0000,
                32'sh0001_0000, '0, 32'sh0001_0000, 32'sh0004_0000};
        send_matrix(a);
        a.m = '{'0, 32'sh0001_0000, '0, '0, '0, 32'sh0001_0000, 32'sh0001_0000, '0, '0};
        send_matrix(a);                                    // permutation
        a.m = '{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                32'sh0005_0000, 32'sh0006_0000, 32'sh0007_0000, 32'sh0008_0000,
                32'sh0009_0000};
        send_matrix(a);                                    // rank two: singular
        a.m = '{-32'sh0003_0000, 32'sh0000_4000, 32'sh0001_8000, 32'sh0000_0001,
                -32'sh0002_0000, 32'sh0000_0010, 32'sh7FFF_0000, 32'sh0000_1000,
                -32'sh0000_8000};
        send_matrix(a);
        repeat (NumRandom) send_matrix(random_matrix());
        s_valid <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off to back the pipeline up.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (!held_off && results_seen >= 100) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HoldOff) @(posedge aclk);
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                if (results_seen % 200 > 150) stall = 0;
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        #5ms;
        $display("** matrix3x3_inverse: FAILED **");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_stimulus();
        while (inv_sb.expected_q.size() != 0) @(posedge aclk);
        repeat (Drain) @(posedge aclk);
        if (inv_sb.errors == 0)
            $display("** matrix3x3_inverse: PASSED **");
        else
            $display("** matrix3x3_inverse: FAILED **");
        $finish;
    end

endmodule
